[rtl/midpoint_line_rasterizer_defines.svh]
// assertion macros shared by the line rasterizer modules
// expects clk and rst_n to be visible in the module that uses them
`ifndef MIDPOINT_LINE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/mlr_pkg.sv]
// shared types and constants of the midpoint line rasterizer
// no dependencies
package mlr_pkg;

    // width of every coordinate port
    localparam int FIELD_W = 6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new segment and set up the walk
        logic emit;   // push the current pixel and advance the walk
        logic busy;   // a walk is in progress
    } mlr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic degenerate; // presented segment has equal endpoints
        logic at_end;     // current pixel is the last one
        logic slot_free;  // output register can take a pixel this cycle
    } mlr_status_t;

endpackage

[rtl/mlr_ctrl.sv]
// controller of the line rasterizer: idle / walk state machine
// depends on mlr_pkg and midpoint_line_rasterizer_defines.svh
`include "midpoint_line_rasterizer_defines.svh"

module mlr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mlr_pkg::mlr_status_t sts,
    output mlr_pkg::mlr_cmd_t    cmd
);
    import mlr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    // an item is taken only between walks
    assign in_stall = (state_reg != ST_IDLE);

    // commands
    always_comb
    begin
        cmd.load = in_valid && (state_reg == ST_IDLE);
        cmd.busy = (state_reg == ST_RUN);
        cmd.emit = (state_reg == ST_RUN) && sts.slot_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && !sts.degenerate)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && sts.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // equal endpoints never start a walk
    `MLR_ASSERT_NEXT(a_degen_stays_idle, cmd.load && sts.degenerate, state_reg == ST_IDLE)
    // a proper segment always starts a walk
    `MLR_ASSERT_NEXT(a_load_starts_walk, cmd.load && !sts.degenerate, state_reg == ST_RUN)
    // the walk ends only after the last pixel went out
    `MLR_ASSERT_NEXT(a_walk_ends, cmd.busy && !(cmd.emit && sts.at_end), state_reg == ST_RUN)

endmodule

[rtl/mlr_datapath.sv]
// datapath of the line rasterizer: octant setup, midpoint walk, output register
// depends on mlr_pkg and midpoint_line_rasterizer_defines.svh
`include "midpoint_line_rasterizer_defines.svh"

module mlr_datapath #(
    parameter int COORD_BITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mlr_pkg::FIELD_W-1:0]   x_start,
    input  logic [mlr_pkg::FIELD_W-1:0]   y_start,
    input  logic [mlr_pkg::FIELD_W-1:0]   x_end,
    input  logic [mlr_pkg::FIELD_W-1:0]   y_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mlr_pkg::FIELD_W-1:0]   pixel_x,
    output logic [mlr_pkg::FIELD_W-1:0]   pixel_y,
    output logic                          last_pixel,
    input  mlr_pkg::mlr_cmd_t             cmd,
    output mlr_pkg::mlr_status_t          sts
);
    import mlr_pkg::*;

    // positions in mapped space carry a sign, the decision variable two more bits
    localparam int P_W = COORD_BITS + 1;
    localparam int D_W = COORD_BITS + 3;

    // setup signals
    logic signed [P_W-1:0] xa0, ya0, xb0, yb0;
    logic signed [P_W-1:0] dx0, dy0, adx, ady;
    logic signed [P_W-1:0] ya1, yb1;
    logic signed [P_W-1:0] xa2, ya2, xb2, yb2;
    logic signed [P_W-1:0] xs, ys, xe, ye;
    logic signed [D_W-1:0] xs_w, ys_w, xe_w, ye_w;
    logic signed [D_W-1:0] a_w, b_w;
    logic                  mirror, swap, rev;

    // walk registers
    logic signed [P_W-1:0] x_reg, x_next;
    logic signed [P_W-1:0] y_reg, y_next;
    logic signed [P_W-1:0] xe_reg, xe_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [D_W-1:0] inc_e_reg, inc_e_next;
    logic signed [D_W-1:0] inc_ne_reg, inc_ne_next;
    logic                  swapped_reg, swapped_next;
    logic                  mirrored_reg, mirrored_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]    pixel_x_reg, pixel_x_next;
    logic [FIELD_W-1:0]    pixel_y_reg, pixel_y_next;
    logic                  last_reg, last_next;

    // mapped back pixel
    logic signed [P_W-1:0] ox, oy, oy_m;

    // octant mapping of the presented segment
    always_comb
    begin
        xa0 = signed'(P_W'(x_start[COORD_BITS-1:0]));
        ya0 = signed'(P_W'(y_start[COORD_BITS-1:0]));
        xb0 = signed'(P_W'(x_end[COORD_BITS-1:0]));
        yb0 = signed'(P_W'(y_end[COORD_BITS-1:0]));
        dx0 = xb0 - xa0;
        dy0 = yb0 - ya0;

        // negate y when the slope is negative
        mirror = ((dx0 < 0) && (dy0 > 0)) || ((dx0 > 0) && (dy0 < 0));
        ya1 = mirror ? -ya0 : ya0;
        yb1 = mirror ? -yb0 : yb0;

        // exchange axes for steep segments
        adx  = (dx0 < 0) ? -dx0 : dx0;
        ady  = (dy0 < 0) ? -dy0 : dy0;
        swap = (adx < ady);
        xa2  = swap ? ya1 : xa0;
        ya2  = swap ? xa0 : ya1;
        xb2  = swap ? yb1 : xb0;
        yb2  = swap ? xb0 : yb1;

        // walk left to right
        rev = (xa2 > xb2);
        xs  = rev ? xb2 : xa2;
        ys  = rev ? yb2 : ya2;
        xe  = rev ? xa2 : xb2;
        ye  = rev ? ya2 : yb2;

        xs_w = D_W'(xs);
        ys_w = D_W'(ys);
        xe_w = D_W'(xe);
        ye_w = D_W'(ye);
        a_w  = ye_w - ys_w;
        b_w  = xs_w - xe_w;
    end

    // map current pixel back to tile coordinates
    always_comb
    begin
        ox   = swapped_reg ? y_reg : x_reg;
        oy   = swapped_reg ? x_reg : y_reg;
        oy_m = mirrored_reg ? -oy : oy;
    end

    // status
    always_comb
    begin
        sts.degenerate = (dx0 == '0) && (dy0 == '0);
        sts.at_end     = (x_reg == xe_reg);
        sts.slot_free  = !out_valid_reg || !out_stall;
    end

    // walk next state: setup on load, one midpoint step per emitted pixel before the last
    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        xe_next       = xe_reg;
        d_next        = d_reg;
        inc_e_next    = inc_e_reg;
        inc_ne_next   = inc_ne_reg;
        swapped_next  = swapped_reg;
        mirrored_next = mirrored_reg;
        if (cmd.load)
        begin
            x_next        = xs;
            y_next        = ys;
            xe_next       = xe;
            d_next        = (a_w <<< 1) + b_w;
            inc_e_next    = a_w <<< 1;
            inc_ne_next   = (a_w + b_w) <<< 1;
            swapped_next  = swap;
            mirrored_next = mirror;
        end
        else if (cmd.emit && !sts.at_end)
        begin
            x_next = x_reg + P_W'(1);
            if (d_reg <= 0)
            begin
                d_next = d_reg + inc_e_reg;
            end
            else
            begin
                d_next = d_reg + inc_ne_reg;
                y_next = y_reg + P_W'(1);
            end
        end
    end

    // output register next state
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            pixel_x_next   = FIELD_W'(ox[COORD_BITS-1:0]);
            pixel_y_next   = FIELD_W'(oy_m[COORD_BITS-1:0]);
            last_next      = sts.at_end;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        xe_reg       <= xe_next;
        d_reg        <= d_next;
        inc_e_reg    <= inc_e_next;
        inc_ne_reg   <= inc_ne_next;
        swapped_reg  <= swapped_next;
        mirrored_reg <= mirrored_next;
        pixel_x_reg  <= pixel_x_next;
        pixel_y_reg  <= pixel_y_next;
        last_reg     <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

    // the walk never runs past the far endpoint
    `MLR_ASSERT_SAME(a_x_in_range, cmd.busy, x_reg <= xe_reg)
    // the minor axis advances by at most one per step
    `MLR_ASSERT_NEXT(a_y_step, cmd.emit && !sts.at_end,
        (y_reg == $past(y_reg)) || (y_reg == $past(y_reg) + P_W'(1)))
    // an emitted pixel is always offered downstream
    `MLR_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_reg && (last_reg == $past(sts.at_end)))

endmodule

[rtl/midpoint_line_rasterizer.sv]
// Midpoint line rasterizer for one square tile: takes a segment as two endpoints
// and emits its pixels, flagging the last one. A segment of max(|dx|,|dy|)+1
// pixels is set up on load and then walked at one pixel per cycle, while the
// output is not stalled, by the decision-variable loop in the datapath.
// The input is stalled while a walk runs; the next segment is taken in the cycle
// after the last pixel enters the output register. Equal endpoints give no
// pixels and start no walk. Only the low COORD_BITS bits of each coordinate
// are used. Depends on mlr_pkg, mlr_ctrl and mlr_datapath.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mlr_pkg::FIELD_W-1:0] x_start,
    input  logic [mlr_pkg::FIELD_W-1:0] y_start,
    input  logic [mlr_pkg::FIELD_W-1:0] x_end,
    input  logic [mlr_pkg::FIELD_W-1:0] y_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mlr_pkg::FIELD_W-1:0] pixel_x,
    output logic [mlr_pkg::FIELD_W-1:0] pixel_y,
    output logic                        last_pixel
);
    import mlr_pkg::*;

    mlr_cmd_t    cmd;
    mlr_status_t sts;

    // state machine
    mlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // setup, walk and output register
    mlr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for midpoint_line_rasterizer: a directed table of segments,
// then random segments, every pixel compared against an in-bench line walk or straight run
// depends on mlr_pkg and midpoint_line_rasterizer
module testbench;

    import mlr_pkg::*;

    localparam int W            = FIELD_W;
    localparam int COORD_BITS   = 6;
    localparam int RANDOM_ITEMS = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 2500;
    localparam int DRAIN_CYCLES = 70;
    localparam int PRINT_CAP    = 40;

    // one emitted pixel
    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic         last;
    } pixel_t;

    // one segment to send; typed rows carry their pixels as start, step and count
    typedef struct packed {
        logic [W-1:0] x0;
        logic [W-1:0] y0;
        logic [W-1:0] x1;
        logic [W-1:0] y1;
        bit           typed;
        logic [W-1:0] px;
        logic [W-1:0] py;
        int           sx;
        int           sy;
        int           count;
    } segment_row_t;

    localparam int DIRECTED_N = 23;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;
    logic         in_valid   = 1'b0;
    logic         in_stall;
    logic [W-1:0] x_start    = '0;
    logic [W-1:0] y_start    = '0;
    logic [W-1:0] x_end      = '0;
    logic [W-1:0] y_end      = '0;
    logic         out_valid;
    logic         out_stall  = 1'b0;
    logic [W-1:0] pixel_x;
    logic [W-1:0] pixel_y;
    logic         last_pixel;

    pixel_t       pending_pixels[$];
    segment_row_t offered_segments[$];
    int           error_count     = 0;
    int           segments_taken  = 0;
    int           empty_segments  = 0;
    int           pixels_checked  = 0;
    int           quiet_cycles    = 0;
    bit           calm            = 1'b0;
    bit           hold_request    = 1'b0;

    // directed segments: extremes, axis lines, diagonals, reversed and mirrored walks
    segment_row_t directed_rows [DIRECTED_N] = '{
        // equal endpoints at both corners
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  0, 0,  0},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 6'd0,  6'd0,  0, 0,  0},
        // full-width horizontal, both directions
        '{6'd0,  6'd0,  6'd63, 6'd0,  1'b1, 6'd0,  6'd0,  1, 0,  64},
        '{6'd63, 6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1, 0,  64},
        // full-height vertical, both directions
        '{6'd5,  6'd0,  6'd5,  6'd63, 1'b1, 6'd5,  6'd0,  0, 1,  64},
        '{6'd5,  6'd63, 6'd5,  6'd0,  1'b1, 6'd5,  6'd0,  0, 1,  64},
        // main diagonal, both directions
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b1, 6'd0,  6'd0,  1, 1,  64},
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1, 1,  64},
        // anti-diagonal, both directions
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b1, 6'd0,  6'd63, 1, -1, 64},
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b1, 6'd0,  6'd63, 1, -1, 64},
        // one-step segments, forward and reversed
        '{6'd10, 6'd10, 6'd11, 6'd10, 1'b1, 6'd10, 6'd10, 1, 0,  2},
        '{6'd63, 6'd63, 6'd62, 6'd63, 1'b1, 6'd62, 6'd63, 1, 0,  2},
        // a decision tie on the first step (goes east), then shallow and steep near-axis lines
        '{6'd0,  6'd0,  6'd2,  6'd1,  1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd0,  6'd0,  6'd1,  6'd63, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        // one segment in each of six octants, then two reversed anti-diagonals
        '{6'd20, 6'd30, 6'd50, 6'd41, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd20, 6'd30, 6'd31, 6'd60, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd20, 6'd30, 6'd9,  6'd60, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd20, 6'd30, 6'd50, 6'd12, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd50, 6'd41, 6'd20, 6'd30, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd31, 6'd60, 6'd20, 6'd30, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0, 6'd0,  6'd0,  0, 0,  0},
        '{6'd63, 6'd0,  6'd62, 6'd1,  1'b0, 6'd0,  6'd0,  0, 0,  0}
    };

    midpoint_line_rasterizer dut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("testbench: mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // midpoint walk in the first octant, pixels mapped back and queued
    function automatic void queue_line_pixels(input segment_row_t seg);
        int  mask;
        int  xa, ya, xb, yb, dx, dy, t;
        int  a, b, d, inc_e, inc_ne, x, y, ox, oy;
        bit  mirrored;
        bit  swapped;
        mask     = (1 << COORD_BITS) - 1;
        xa       = int'(seg.x0) & mask;
        ya       = int'(seg.y0) & mask;
        xb       = int'(seg.x1) & mask;
        yb       = int'(seg.y1) & mask;
        dx       = xb - xa;
        dy       = yb - ya;
        mirrored = 1'b0;
        swapped  = 1'b0;
        if (dx == 0 && dy == 0)
            return;
        // opposite signs: flip y
        if ((dx < 0 && dy > 0) || (dx > 0 && dy < 0))
        begin
            ya       = -ya;
            yb       = -yb;
            dy       = -dy;
            mirrored = 1'b1;
        end
        // steep: exchange axes
        if ((dx < 0 ? -dx : dx) < (dy < 0 ? -dy : dy))
        begin
            t = xa; xa = ya; ya = t;
            t = xb; xb = yb; yb = t;
            swapped = 1'b1;
        end
        // walk left to right
        if (xa > xb)
        begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        a      = yb - ya;
        b      = xa - xb;
        inc_e  = 2 * a;
        inc_ne = 2 * (a + b);
        d      = 2 * a + b;
        x      = xa;
        y      = ya;
        forever
        begin
            ox = swapped ? y : x;
            oy = swapped ? x : y;
            if (mirrored)
                oy = -oy;
            ox = ox & mask;
            oy = oy & mask;
            pending_pixels.push_back('{ox[W-1:0], oy[W-1:0], x >= xb});
            if (x >= xb)
                break;
            if (d <= 0)
            begin
                d += inc_e;
            end
            else
            begin
                d += inc_ne;
                y++;
            end
            x++;
        end
    endfunction

    // typed rows: straight run from a start pixel by a fixed step
    function automatic void queue_straight_run(input segment_row_t seg);
        int vx;
        int vy;
        for (int i = 0; i < seg.count; i++)
        begin
            vx = int'(seg.px) + i * seg.sx;
            vy = int'(seg.py) + i * seg.sy;
            pending_pixels.push_back('{vx[W-1:0], vy[W-1:0], i == seg.count - 1});
        end
    endfunction

    function automatic segment_row_t random_segment();
        segment_row_t seg;
        int           kind;
        int           len;
        seg      = '0;
        kind     = $urandom_range(99);
        seg.x0   = W'($urandom_range(63));
        seg.y0   = W'($urandom_range(63));
        seg.x1   = W'($urandom_range(63));
        seg.y1   = W'($urandom_range(63));
        if (kind < 8)
        begin
            // equal endpoints
            seg.x1 = seg.x0;
            seg.y1 = seg.y0;
        end
        else if (kind < 28)
        begin
            // short segment around the start, wrapping at the tile edge
            seg.x1 = seg.x0 + W'($urandom_range(8)) - W'(4);
            seg.y1 = seg.y0 + W'($urandom_range(8)) - W'(4);
        end
        else if (kind < 40)
        begin
            // axis or diagonal of random length
            len = $urandom_range(63);
            case ($urandom_range(3))
                0: seg.y1 = seg.y0;
                1: seg.x1 = seg.x0;
                2: seg.y1 = seg.y0 + (seg.x1 - seg.x0);
                default: seg.y1 = seg.y0 - (seg.x1 - seg.x0);
            endcase
            if (len == 0)
                seg.x1 = seg.x0 ^ 6'h3f;
        end
        return seg;
    endfunction

    // offer one item and hold it until taken
    task automatic send_segment(input segment_row_t seg);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        offered_segments.push_back(seg);
        in_valid <= 1'b1;
        x_start  <= seg.x0;
        y_start  <= seg.y0;
        x_end    <= seg.x1;
        y_end    <= seg.y1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // reset
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 11);
            end
        end
    end

    // monitor: queue predictions on item accept, check pixels on output accept
    always @(posedge clk)
    begin : pixel_monitor
        segment_row_t seg;
        pixel_t       want;
        int           queued_before;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                queued_before = pending_pixels.size();
                if (offered_segments.size() == 0)
                begin
                    flag_mismatch("item taken that was never offered");
                end
                else
                begin
                    seg = offered_segments.pop_front();
                    if (seg.typed)
                        queue_straight_run(seg);
                    else
                        queue_line_pixels(seg);
                end
                segments_taken++;
                if (pending_pixels.size() == queued_before)
                    empty_segments++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    flag_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                            pixel_x, pixel_y));
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_x !== want.x)
                        flag_mismatch($sformatf("pixel_x %0d, expected %0d",
                                                pixel_x, want.x));
                    if (pixel_y !== want.y)
                        flag_mismatch($sformatf("pixel_y %0d, expected %0d",
                                                pixel_y, want.y));
                    if (last_pixel !== want.last)
                        flag_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                                last_pixel, want.last, want.x, want.y));
                end
                pixels_checked++;
            end
        end
    end

    // watchdog on cycles without any accepted item or pixel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("testbench: no progress for %0d cycles, %0d pixels outstanding",
                             quiet_cycles, pending_pixels.size());
                    $display("testbench: done, errors");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_N; i++)
            send_segment(directed_rows[i]);

        // random segments with one hold-off, one drain pause and one calm stretch
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                hold_request = 1'b1;
            if (i == 130)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_pixels.size() != 0 || offered_segments.size() != 0);
            end
            calm = (i >= 200 && i < 280);
            send_segment(random_segment());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then let any stray pixel show up
        do
            @(posedge clk);
        while (pending_pixels.size() != 0 || offered_segments.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("testbench: %0d segments taken, %0d empty, %0d pixels checked",
                 segments_taken, empty_segments, pixels_checked);
        $display("testbench: axis, diagonal, steep, mirrored and reversed walks under stalls");
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
